FILE: design/led_scanner_and_stopwatch_unit_defines.svh
// assertion macros for the led scanner and stopwatch controller
`ifndef LED_SCANNER_AND_STOPWATCH_UNIT_DEFINES_SVH
`define LED_SCANNER_AND_STOPWATCH_UNIT_DEFINES_SVH

// check on every rising clock edge outside reset
`define LSSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that also runs while reset is held
`define LSSU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: design/lssu_pkg.sv
// shared types, constants and helper functions for the led scanner and stopwatch
package lssu_pkg;

    // default width of the stopwatch counter
    localparam int COUNT_BITS_DEF = 8;

    // accumulator saturation value
    localparam logic [10:0] ACCUM_MAX = 11'd2047;

    // configuration register indexes
    localparam logic [2:0] CFG_TICK_MS       = 3'd0;
    localparam logic [2:0] CFG_DELAY_STEP_MS = 3'd1;
    localparam logic [2:0] CFG_DELAY_MIN_MS  = 3'd2;
    localparam logic [2:0] CFG_DELAY_MAX_MS  = 3'd3;
    localparam logic [2:0] CFG_SECOND_MS     = 3'd4;

    // configuration reset values
    localparam logic [7:0] TICK_MS_RST       = 8'd8;
    localparam logic [7:0] DELAY_STEP_MS_RST = 8'd50;
    localparam logic [9:0] DELAY_MIN_MS_RST  = 10'd50;
    localparam logic [9:0] DELAY_MAX_MS_RST  = 10'd1000;
    localparam logic [9:0] SECOND_MS_RST     = 10'd1000;
    localparam logic [9:0] SCAN_DELAY_RST    = 10'd500;

    // button bit positions
    localparam int BTN_START  = 0;
    localparam int BTN_STOP   = 1;
    localparam int BTN_CLEAR  = 2;
    localparam int BTN_SLOWER = 3;
    localparam int BTN_FASTER = 4;

    // led bar patterns, outer pairs first
    localparam logic [7:0] LED_OFF   = 8'h00;
    localparam logic [7:0] LED_BAR_1 = 8'b10000000 | 8'b00000001;
    localparam logic [7:0] LED_BAR_2 = 8'hC3;
    localparam logic [7:0] LED_BAR_3 = 8'hE7;
    localparam logic [7:0] LED_FULL  = 8'b11110000 | 8'b00001111;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic apply;
        logic scan_step;
        logic sec_step;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_more;
        logic sec_more;
    } t_dp_status;

    // scanner state
    typedef struct packed {
        logic [2:0] pos;
        logic       up;
        logic [7:0] led;
    } t_scan;

    // saturating accumulator add
    function automatic logic [10:0] accum_add(input logic [10:0] a, input logic [7:0] b);
        logic [11:0] sum;
        sum = {1'b0, a} + {4'b0, b};
        return (sum > {1'b0, ACCUM_MAX}) ? ACCUM_MAX : sum[10:0];
    endfunction

    // one step of the mirrored bar scanner
    function automatic t_scan scan_advance(input t_scan s);
        t_scan n;
        n = s;
        unique case (s.pos)
            3'd0: begin
                n.led = LED_OFF;
                n.up  = 1'b1;
                n.pos = 3'd1;
            end
            3'd1, 3'd2, 3'd3: begin
                n.led = (s.pos == 3'd1) ? LED_BAR_1 : (s.pos == 3'd2) ? LED_BAR_2 : LED_BAR_3;
                n.pos = s.up ? s.pos + 3'd1 : s.pos - 3'd1;
            end
            3'd4: begin
                n.led = LED_FULL;
                n.up  = 1'b0;
                n.pos = 3'd3;
            end
            default: begin
                n.pos = 3'd0;
                n.up  = 1'b0;
            end
        endcase
        return n;
    endfunction

endpackage

FILE: design/lssu_ctrl.sv
// controller state machine: request handshakes and drain sequencing
`include "led_scanner_and_stopwatch_unit_defines.svh"

module lssu_ctrl
    import lssu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_sts,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_in_acc;
    logic   w_out_free;
    logic   w_done;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_done     = !i_sts.scan_more && !i_sts.sec_more;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (w_done && w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.apply = i_in_valid;
            end
            ST_DRAIN: begin
                o_cmd.scan_step = i_sts.scan_more;
                o_cmd.sec_step  = i_sts.sec_more;
                o_cmd.load_out  = w_done && w_out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    // result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // checks
    `LSSU_ASSERT(a_load_sets_valid, o_cmd.load_out |=> r_out_valid, "result load lost")
    `LSSU_ASSERT(a_no_overwrite, o_cmd.load_out |-> (!r_out_valid || !i_out_stall), "held result overwritten")
    `LSSU_ASSERT(a_load_after_drain, o_cmd.load_out |-> !(i_sts.scan_more || i_sts.sec_more), "result loaded before drain done")
    `LSSU_ASSERT_RST(a_reset_clears, !i_rst_n |=> (!r_out_valid && r_state == ST_IDLE), "reset did not clear control")

endmodule

FILE: design/lssu_dp.sv
// datapath: configuration, button handling, accumulators, scanner and result register
module lssu_dp
    import lssu_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_index,
    input  logic [9:0] i_cfg_data,
    input  logic [4:0] i_buttons,
    input  logic       i_tick,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_sts,
    output logic [7:0] o_led_pattern,
    output logic [7:0] o_seconds,
    output logic [9:0] o_scan_delay_now
);

    localparam int EXT_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;

    // configuration registers
    logic [7:0] r_tick_ms;
    logic [7:0] r_delay_step_ms;
    logic [9:0] r_delay_min_ms;
    logic [9:0] r_delay_max_ms;
    logic [9:0] r_second_ms;

    // block state
    logic [4:0]            r_button_prev;
    logic                  r_running, n_running;
    logic [10:0]           r_second_accum;
    logic [10:0]           r_scan_accum;
    logic [9:0]            r_scan_delay, n_scan_delay;
    t_scan                 r_scan;
    logic [COUNT_BITS-1:0] r_count;

    // result register
    logic [7:0] r_out_led;
    logic [7:0] r_out_sec;
    logic [9:0] r_out_delay;

    logic [4:0]       w_rise;
    logic [10:0]      w_slow_sum;
    logic [9:0]       w_delay_slow;
    logic signed [11:0] w_fast_diff;
    logic [EXT_W-1:0] w_count_ext;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_ms       <= TICK_MS_RST;
            r_delay_step_ms <= DELAY_STEP_MS_RST;
            r_delay_min_ms  <= DELAY_MIN_MS_RST;
            r_delay_max_ms  <= DELAY_MAX_MS_RST;
            r_second_ms     <= SECOND_MS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TICK_MS:       r_tick_ms       <= i_cfg_data[7:0];
                CFG_DELAY_STEP_MS: r_delay_step_ms <= i_cfg_data[7:0];
                CFG_DELAY_MIN_MS:  r_delay_min_ms  <= i_cfg_data;
                CFG_DELAY_MAX_MS:  r_delay_max_ms  <= i_cfg_data;
                CFG_SECOND_MS:     r_second_ms     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // button edges, start then stop
    assign w_rise = i_buttons & ~r_button_prev;

    always_comb begin
        n_running = r_running;
        if (w_rise[BTN_START]) n_running = 1'b1;
        if (w_rise[BTN_STOP])  n_running = 1'b0;
    end

    // slower clamps to the maximum, then faster clamps to the minimum
    assign w_slow_sum   = {1'b0, r_scan_delay} + {3'b0, r_delay_step_ms};
    assign w_delay_slow = !w_rise[BTN_SLOWER] ? r_scan_delay :
                          (w_slow_sum > {1'b0, r_delay_max_ms}) ? r_delay_max_ms :
                          w_slow_sum[9:0];
    assign w_fast_diff  = $signed({2'b0, w_delay_slow}) - $signed({4'b0, r_delay_step_ms});

    always_comb begin
        n_scan_delay = w_delay_slow;
        if (w_rise[BTN_FASTER]) begin
            if (w_fast_diff < $signed({2'b0, r_delay_min_ms})) begin
                n_scan_delay = r_delay_min_ms;
            end else begin
                n_scan_delay = w_fast_diff[9:0];
            end
        end
    end

    // drain status
    assign o_sts.scan_more = (r_scan_delay != 10'd0) && (r_scan_accum >= {1'b0, r_scan_delay});
    assign o_sts.sec_more  = (r_second_ms != 10'd0) && (r_second_accum >= {1'b0, r_second_ms});

    // state update: request apply, then one drain step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_prev  <= '0;
            r_running      <= 1'b0;
            r_second_accum <= '0;
            r_scan_accum   <= '0;
            r_scan_delay   <= SCAN_DELAY_RST;
            r_scan         <= '0;
            r_count        <= '0;
        end else if (i_cmd.apply) begin
            r_button_prev <= i_buttons;
            r_running     <= n_running;
            r_scan_delay  <= n_scan_delay;
            if (w_rise[BTN_CLEAR]) r_count <= '0;
            if (i_tick) begin
                r_scan_accum <= accum_add(r_scan_accum, r_tick_ms);
                if (n_running) r_second_accum <= accum_add(r_second_accum, r_tick_ms);
            end
        end else begin
            if (i_cmd.scan_step) begin
                r_scan_accum <= r_scan_accum - {1'b0, r_scan_delay};
                r_scan       <= scan_advance(r_scan);
            end
            if (i_cmd.sec_step) begin
                r_second_accum <= r_second_accum - {1'b0, r_second_ms};
                r_count        <= r_count + COUNT_BITS'(1);
            end
        end
    end

    // result register
    assign w_count_ext = EXT_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_led   <= r_scan.led;
            r_out_sec   <= w_count_ext[7:0];
            r_out_delay <= r_scan_delay;
        end
    end

    assign o_led_pattern    = r_out_led;
    assign o_seconds        = r_out_sec;
    assign o_scan_delay_now = r_out_delay;

endmodule

FILE: design/led_scanner_and_stopwatch_unit.sv
// Mirrored LED bar scanner with a stopwatch: request in, one result out per request.
//
// Input channel: i_in_valid / o_in_stall carry i_buttons and i_tick. A request is
// taken when valid is high and stall is low. Output channel: o_out_valid /
// i_out_stall carry o_led_pattern, o_seconds and o_scan_delay_now.
// Configuration: i_cfg_wr_en writes i_cfg_data to register i_cfg_index
// (0 tick_ms, 1 delay_step_ms, 2 delay_min_ms, 3 delay_max_ms, 4 second_ms);
// the user must write only while no request is in flight (not enforced).
// The request is applied in the cycle it is taken, then the scan and seconds
// accumulators drain in parallel, one subtraction each per cycle, and the result
// is loaded once both are drained and the output register is free. The result
// sits in an output register, so the next request is taken while the previous
// result is still waiting; a stalled receiver only holds up completion of that
// next request. Synchronous reset clears the control and datapath state but not
// the result data, loads the default configuration and a scan delay of 500 ms,
// and empties the output.
module led_scanner_and_stopwatch_unit
    import lssu_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_index,
    input  logic [9:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [4:0] i_buttons,
    input  logic       i_tick,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_led_pattern,
    output logic [7:0] o_seconds,
    output logic [9:0] o_scan_delay_now
);

    t_dp_cmd    w_cmd;
    t_dp_status w_sts;

    // controller
    lssu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath
    lssu_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_buttons        (i_buttons),
        .i_tick           (i_tick),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_led_pattern    (o_led_pattern),
        .o_seconds        (o_seconds),
        .o_scan_delay_now (o_scan_delay_now)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench for the led scanner and stopwatch unit: random and directed requests against a predictor
module testbench
    import lssu_pkg::*;
();

    localparam int COUNT_W     = COUNT_BITS_DEF;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int TAIL_CYCLES = 20;

    // one button mask per function
    localparam logic [4:0] B_START  = 5'd1 << BTN_START;
    localparam logic [4:0] B_STOP   = 5'd1 << BTN_STOP;
    localparam logic [4:0] B_CLEAR  = 5'd1 << BTN_CLEAR;
    localparam logic [4:0] B_SLOWER = 5'd1 << BTN_SLOWER;
    localparam logic [4:0] B_FASTER = 5'd1 << BTN_FASTER;

    typedef struct packed {
        logic [4:0] btn;
        logic       tick;
    } t_press;

    typedef struct packed {
        logic [7:0] led;
        logic [7:0] secs;
        logic [9:0] delay;
    } t_display;

    logic       i_clk;
    logic       i_rst_n          = 1'b0;
    logic       i_cfg_wr_en      = 1'b0;
    logic [2:0] i_cfg_index      = CFG_TICK_MS;
    logic [9:0] i_cfg_data       = '0;
    logic       i_in_valid       = 1'b0;
    logic       o_in_stall;
    logic [4:0] i_buttons        = '0;
    logic       i_tick           = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall      = 1'b0;
    logic [7:0] o_led_pattern;
    logic [7:0] o_seconds;
    logic [9:0] o_scan_delay_now;

    t_press   press_queue[$];
    t_display due_displays[$];
    logic     in_taken       = 1'b0;
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // predictor copy of the configuration
    logic [7:0] cfg_tick = TICK_MS_RST;
    logic [7:0] cfg_step = DELAY_STEP_MS_RST;
    logic [9:0] cfg_min  = DELAY_MIN_MS_RST;
    logic [9:0] cfg_max  = DELAY_MAX_MS_RST;
    logic [9:0] cfg_sec  = SECOND_MS_RST;

    // predictor copy of the state
    logic [4:0]         btn_last    = '0;
    logic               run_flag    = 1'b0;
    logic [10:0]        sec_acc     = '0;
    logic [10:0]        scan_acc    = '0;
    logic [9:0]         scan_ms     = SCAN_DELAY_RST;
    logic [2:0]         scan_pos    = '0;
    logic               scan_rising = 1'b0;
    logic [7:0]         leds        = LED_OFF;
    logic [COUNT_W-1:0] sec_cnt     = '0;

    led_scanner_and_stopwatch_unit #(
        .COUNT_BITS(COUNT_W)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_buttons       (i_buttons),
        .i_tick          (i_tick),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_led_pattern   (o_led_pattern),
        .o_seconds       (o_seconds),
        .o_scan_delay_now(o_scan_delay_now)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // accumulator add, held at the top of its range
    function automatic logic [10:0] acc_plus(input logic [10:0] acc, input logic [7:0] ms);
        logic [11:0] total;
        total = {1'b0, acc} + {4'b0, ms};
        return (total > {1'b0, ACCUM_MAX}) ? ACCUM_MAX : total[10:0];
    endfunction

    // apply one request to the predictor state and return the display it shows
    function automatic t_display predict_display(input logic [4:0] btn, input logic tick);
        logic [4:0]  rise;
        int unsigned longer;
        int          shorter;
        t_display    shown;
        rise = btn & ~btn_last;
        if (rise[BTN_START]) run_flag = 1'b1;
        if (rise[BTN_STOP]) run_flag = 1'b0;
        if (rise[BTN_CLEAR]) sec_cnt = '0;
        if (rise[BTN_SLOWER]) begin
            longer = scan_ms + cfg_step;
            if (longer > cfg_max) longer = cfg_max;
            scan_ms = longer[9:0];
        end
        if (rise[BTN_FASTER]) begin
            shorter = int'(scan_ms) - int'(cfg_step);
            if (shorter < int'(cfg_min)) shorter = int'(cfg_min);
            scan_ms = shorter[9:0];
        end
        btn_last = btn;

        // tick feeds the scan accumulator always, the stopwatch only while running
        if (tick) begin
            scan_acc = acc_plus(scan_acc, cfg_tick);
            if (run_flag) sec_acc = acc_plus(sec_acc, cfg_tick);
        end

        // one scanner move per full scan delay
        if (scan_ms != '0) begin
            while (scan_acc >= scan_ms) begin
                scan_acc = scan_acc - scan_ms;
                case (scan_pos)
                    3'd0: begin
                        leds        = LED_OFF;
                        scan_rising = 1'b1;
                        scan_pos    = 3'd1;
                    end
                    3'd1, 3'd2, 3'd3: begin
                        leds = (scan_pos == 3'd1) ? LED_BAR_1 :
                               (scan_pos == 3'd2) ? LED_BAR_2 : LED_BAR_3;
                        scan_pos = scan_rising ? scan_pos + 3'd1 : scan_pos - 3'd1;
                    end
                    3'd4: begin
                        leds        = LED_FULL;
                        scan_rising = 1'b0;
                        scan_pos    = 3'd3;
                    end
                    default: begin
                        scan_pos    = 3'd0;
                        scan_rising = 1'b0;
                    end
                endcase
            end
        end

        // one count per full second
        if (cfg_sec != '0) begin
            while (sec_acc >= cfg_sec) begin
                sec_acc = sec_acc - cfg_sec;
                sec_cnt = sec_cnt + 1'b1;
            end
        end

        shown.led   = leds;
        shown.secs  = sec_cnt[7:0];
        shown.delay = scan_ms;
        return shown;
    endfunction

    // request driver, one slot at a time
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (press_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t_press next_press;
                next_press = press_queue.pop_front();
                i_buttons  <= next_press.btn;
                i_tick     <= next_press.tick;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result check, then prediction for a request taken at the same edge
    always @(posedge i_clk) begin : result_check
        t_display want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_displays.size() == 0) begin
                    $error("unexpected result: led_pattern %h seconds %0d scan_delay_now %0d",
                           o_led_pattern, o_seconds, o_scan_delay_now);
                    mismatch_count++;
                end else begin
                    want = due_displays.pop_front();
                    if (o_led_pattern !== want.led) begin
                        $error("led_pattern: expected %h, got %h", want.led, o_led_pattern);
                        mismatch_count++;
                    end
                    if (o_seconds !== want.secs) begin
                        $error("seconds: expected %0d, got %0d", want.secs, o_seconds);
                        mismatch_count++;
                    end
                    if (o_scan_delay_now !== want.delay) begin
                        $error("scan_delay_now: expected %0d, got %0d",
                               want.delay, o_scan_delay_now);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall)
                due_displays.push_back(predict_display(i_buttons, i_tick));
            in_taken <= i_in_valid && !o_in_stall;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_one(input logic [4:0] btn, input logic tick);
        t_press p;
        p.btn  = btn;
        p.tick = tick;
        press_queue.push_back(p);
    endtask

    // press and release a button n times, ticking throughout
    task automatic push_presses(input logic [4:0] btn, input int n);
        for (int k = 0; k < n; k++) begin
            push_one(btn, 1'b1);
            push_one('0, 1'b1);
        end
    endtask

    // wait until every request is sent and every result has come back
    task automatic wait_idle();
        while (press_queue.size() != 0 || i_in_valid || due_displays.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_TICK_MS:       cfg_tick = val[7:0];
            CFG_DELAY_STEP_MS: cfg_step = val[7:0];
            CFG_DELAY_MIN_MS:  cfg_min  = val;
            CFG_DELAY_MAX_MS:  cfg_max  = val;
            CFG_SECOND_MS:     cfg_sec  = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [9:0] tick_ms, input logic [9:0] step_ms,
                                 input logic [9:0] min_ms, input logic [9:0] max_ms,
                                 input logic [9:0] sec_ms);
        write_reg(CFG_TICK_MS, tick_ms);
        write_reg(CFG_DELAY_STEP_MS, step_ms);
        write_reg(CFG_DELAY_MIN_MS, min_ms);
        write_reg(CFG_DELAY_MAX_MS, max_ms);
        write_reg(CFG_SECOND_MS, sec_ms);
    endtask

    // mostly sparse presses with ticks, some pure noise
    task automatic run_random(input int n);
        logic [4:0] btn;
        logic       tick;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) begin
                btn  = 5'($urandom);
                tick = 1'($urandom);
            end else begin
                btn = '0;
                btn[BTN_START]  = ($urandom_range(99) < 15);
                btn[BTN_STOP]   = ($urandom_range(99) < 5);
                btn[BTN_CLEAR]  = ($urandom_range(99) < 3);
                btn[BTN_SLOWER] = ($urandom_range(99) < 10);
                btn[BTN_FASTER] = ($urandom_range(99) < 10);
                tick = ($urandom_range(99) < 75);
            end
            push_one(btn, tick);
        end
        wait_idle();
    endtask

    // stimulus sequence
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: every button edge, extremes of the fields
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_one('0, 1'b0);
        push_one(B_START | B_STOP | B_CLEAR | B_SLOWER | B_FASTER, 1'b0);
        push_one(B_START | B_STOP | B_CLEAR | B_SLOWER | B_FASTER, 1'b1);
        push_one('0, 1'b1);
        push_one(B_START, 1'b1);
        push_one(B_STOP, 1'b1);
        push_one(B_START, 1'b1);
        push_one('0, 1'b1);
        push_one(B_START | B_STOP, 1'b1);
        push_one(B_CLEAR, 1'b0);
        push_one(B_SLOWER, 1'b1);
        push_one(B_FASTER, 1'b1);
        run_random(100);

        // largest tick and step, widest delay range, fastest second
        load_settings(10'd255, 10'd255, 10'd1, 10'd1023, 10'd1);
        send_idle_pct  = 67;
        recv_stall_pct = 0;
        push_presses(B_SLOWER, 3);
        push_presses(B_START, 1);
        push_presses(B_FASTER, 5);
        run_random(100);

        // min above max, smallest tick and step, slowest second
        load_settings(10'd1, 10'd1, 10'd1023, 10'd1, 10'd1023);
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        push_presses(B_SLOWER, 1);
        push_presses(B_FASTER, 1);
        run_random(100);

        // zero second length and a floor of zero, so the delay can reach zero
        load_settings(10'd255, 10'd255, 10'd0, 10'd1023, 10'd0);
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        push_presses(B_START, 1);
        push_presses(B_FASTER, 4);
        run_random(60);

        // mid-range settings, draining what the zero settings left behind
        load_settings(10'd100, 10'd7, 10'd20, 10'd600, 10'd300);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_presses(B_FASTER, 1);
        run_random(120);

        // fixed delay, fast ticks
        load_settings(10'd255, 10'd200, 10'd1023, 10'd1023, 10'd1);
        send_idle_pct  = 67;
        recv_stall_pct = 0;
        run_random(100);

        // back to the reset settings
        load_settings(TICK_MS_RST, DELAY_STEP_MS_RST, DELAY_MIN_MS_RST, DELAY_MAX_MS_RST,
                      SECOND_MS_RST);
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        run_random(100);

        // random settings, with stray upper bits on the 8-bit registers
        load_settings({2'($urandom), 8'($urandom_range(255, 1))},
                      {2'($urandom), 8'($urandom_range(255, 1))},
                      10'($urandom_range(1023, 1)), 10'($urandom_range(1023, 1)),
                      10'($urandom_range(1023, 1)));
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        run_random(70);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
